FILE: design/rar_pkg.sv
package rar_pkg;

  localparam int OPERAND_WIDTH = 32;
  localparam int NUM_W = OPERAND_WIDTH;
  localparam int DEN_W = OPERAND_WIDTH - 1;
  localparam int PROD_W = 2 * OPERAND_WIDTH;
  localparam int SDEN_W = PROD_W - 1;
  localparam int CNT_W = $clog2(PROD_W + 1);

  typedef struct packed {
    logic load;
    logic mul_ad;
    logic mul_cb;
    logic mul_bd;
    logic absval;
    logic gcd_step;
    logic div_start;
    logic div_sel;
    logic take_qn;
    logic take_qd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic gcd_done;
    logic div_done;
  } stat_t;

  localparam logic DIV_SEL_NUM = 1'b0;
  localparam logic DIV_SEL_DEN = 1'b1;

endpackage

FILE: design/rational_add_reduce_core.sv
// Channel   Handshake            Words
// input     start, busy          left_num, left_den, right_num, right_den
// result    done (one cycle)     sum_num, sum_den, bad_den
//
// A word is loaded and cross-multiplied, then runs the binary gcd loop, and ends
// with two 64-step divisions on the shared restoring divider, each begun by its
// own start. A zero denominator skips the arithmetic and goes straight to the result.
// Reset is synchronous and returns the controller to idle with no result pending.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rational_add_reduce_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [rar_pkg::NUM_W-1:0]  left_num,
  input  logic        [rar_pkg::DEN_W-1:0]  left_den,
  input  logic signed [rar_pkg::NUM_W-1:0]  right_num,
  input  logic        [rar_pkg::DEN_W-1:0]  right_den,
  output logic                              done,
  output logic signed [rar_pkg::PROD_W-1:0] sum_num,
  output logic        [rar_pkg::SDEN_W-1:0] sum_den,
  output logic                              bad_den
);

  rar_pkg::cmd_t  cmd;
  rar_pkg::stat_t stat;

  rar_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  rar_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .left_num  (left_num),
    .left_den  (left_den),
    .right_num (right_num),
    .right_den (right_den),
    .sum_num   (sum_num),
    .sum_den   (sum_den),
    .bad_den   (bad_den),
    .done      (done)
  );

endmodule

FILE: design/rar_div.sv
module rar_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rar_pkg::PROD_W-1:0] dividend,
  input  logic [rar_pkg::PROD_W-1:0] divisor,
  output logic                       done,
  output logic [rar_pkg::PROD_W-1:0] quotient
);

  logic                       running;
  logic [rar_pkg::CNT_W-1:0]  cnt;
  logic [rar_pkg::PROD_W-1:0] rem;
  logic [rar_pkg::PROD_W-1:0] quo;
  logic [rar_pkg::PROD_W-1:0] shifted;
  logic [rar_pkg::PROD_W:0]   diff;

  assign shifted = {rem[rar_pkg::PROD_W-2:0], quo[rar_pkg::PROD_W-1]};
  assign diff = {1'b0, shifted} - {1'b0, divisor};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt <= rar_pkg::CNT_W'(rar_pkg::PROD_W);
      end else if (running) begin
        cnt <= cnt - rar_pkg::CNT_W'(1);
        if (cnt == rar_pkg::CNT_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
    end else if (running) begin
      if (diff[rar_pkg::PROD_W]) begin
        rem <= shifted;
        quo <= {quo[rar_pkg::PROD_W-2:0], 1'b0};
      end else begin
        rem <= diff[rar_pkg::PROD_W-1:0];
        quo <= {quo[rar_pkg::PROD_W-2:0], 1'b1};
      end
    end
  end

endmodule

FILE: design/rar_dp.sv
module rar_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  rar_pkg::cmd_t                     cmd,
  output rar_pkg::stat_t                    stat,
  input  logic signed [rar_pkg::NUM_W-1:0]  left_num,
  input  logic        [rar_pkg::DEN_W-1:0]  left_den,
  input  logic signed [rar_pkg::NUM_W-1:0]  right_num,
  input  logic        [rar_pkg::DEN_W-1:0]  right_den,
  output logic signed [rar_pkg::PROD_W-1:0] sum_num,
  output logic        [rar_pkg::SDEN_W-1:0] sum_den,
  output logic                              bad_den,
  output logic                              done
);

  logic signed [rar_pkg::NUM_W-1:0]  a;
  logic signed [rar_pkg::NUM_W-1:0]  c;
  logic        [rar_pkg::DEN_W-1:0]  b;
  logic        [rar_pkg::DEN_W-1:0]  d;
  logic                              bad;
  logic signed [rar_pkg::PROD_W-1:0] r_ad;
  logic signed [rar_pkg::PROD_W-1:0] r_cb;
  logic signed [rar_pkg::PROD_W-1:0] r_sum;
  logic        [rar_pkg::PROD_W-1:0] r_bd;
  logic                              neg;
  logic        [rar_pkg::PROD_W-1:0] u;
  logic        [rar_pkg::PROD_W-1:0] v;
  logic        [rar_pkg::PROD_W-1:0] mq;
  logic        [rar_pkg::PROD_W-1:0] dq;
  logic        [rar_pkg::PROD_W-1:0] qn;
  logic        [rar_pkg::PROD_W-1:0] qd;
  logic        [rar_pkg::PROD_W-1:0] div_q;
  logic        [rar_pkg::PROD_W-1:0] div_a;
  logic                              div_done;
  logic signed [rar_pkg::NUM_W-1:0]  mul_x;
  logic signed [rar_pkg::NUM_W-1:0]  mul_y;
  logic signed [rar_pkg::PROD_W-1:0] prod;
  logic                              u_ge_v;
  logic        [rar_pkg::PROD_W-1:0] u_minus_v;
  logic        [rar_pkg::PROD_W-1:0] v_minus_u;

  always_comb begin
    priority if (cmd.mul_ad) begin
      mul_x = a;
      mul_y = $signed({1'b0, d});
    end else if (cmd.mul_cb) begin
      mul_x = c;
      mul_y = $signed({1'b0, b});
    end else begin
      mul_x = $signed({1'b0, b});
      mul_y = $signed({1'b0, d});
    end
  end

  assign prod = mul_x * mul_y;
  assign u_ge_v = u >= v;
  assign u_minus_v = u - v;
  assign v_minus_u = v - u;
  assign div_a = (cmd.div_sel == rar_pkg::DIV_SEL_NUM) ? mq : dq;

  assign stat.bad = bad;
  assign stat.gcd_done = (u == '0);
  assign stat.div_done = div_done;

  rar_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (v),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a <= left_num;
      b <= left_den;
      c <= right_num;
      d <= right_den;
      bad <= (left_den == '0) || (right_den == '0);
    end
    if (cmd.mul_ad) begin
      r_ad <= prod;
    end
    if (cmd.mul_cb) begin
      r_cb <= prod;
    end
    if (cmd.mul_bd) begin
      r_bd <= prod;
      r_sum <= r_ad + r_cb;
    end
    if (cmd.absval) begin
      neg <= r_sum[rar_pkg::PROD_W-1];
      u <= r_sum[rar_pkg::PROD_W-1] ? -r_sum : r_sum;
      mq <= r_sum[rar_pkg::PROD_W-1] ? -r_sum : r_sum;
      v <= r_bd;
      dq <= r_bd;
    end
    if (cmd.gcd_step) begin
      priority if (!u[0] && !v[0]) begin
        u <= u >> 1;
        v <= v >> 1;
        mq <= mq >> 1;
        dq <= dq >> 1;
      end else if (!u[0]) begin
        u <= u >> 1;
      end else if (!v[0]) begin
        v <= v >> 1;
      end else if (u_ge_v) begin
        u <= u_minus_v >> 1;
      end else begin
        v <= v_minus_u >> 1;
      end
    end
    if (cmd.take_qn) begin
      qn <= div_q;
    end
    if (cmd.take_qd) begin
      qd <= div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (bad) begin
        sum_num <= '0;
        sum_den <= rar_pkg::SDEN_W'(1);
        bad_den <= 1'b1;
      end else begin
        sum_num <= neg ? -$signed(qn) : $signed(qn);
        sum_den <= qd[rar_pkg::SDEN_W-1:0];
        bad_den <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

FILE: design/rar_ctrl.sv
module rar_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  output rar_pkg::cmd_t  cmd,
  input  rar_pkg::stat_t stat
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CHECK  = 12'b000000000010,
    S_MUL_AD = 12'b000000000100,
    S_MUL_CB = 12'b000000001000,
    S_MUL_BD = 12'b000000010000,
    S_ABS    = 12'b000000100000,
    S_GCD    = 12'b000001000000,
    S_DN_GO  = 12'b000010000000,
    S_DN     = 12'b000100000000,
    S_DD_GO  = 12'b001000000000,
    S_DD     = 12'b010000000000,
    S_EMIT   = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.div_sel = rar_pkg::DIV_SEL_NUM;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = stat.bad ? S_EMIT : S_MUL_AD;
      end
      S_MUL_AD: begin
        cmd.mul_ad = 1'b1;
        state_next = S_MUL_CB;
      end
      S_MUL_CB: begin
        cmd.mul_cb = 1'b1;
        state_next = S_MUL_BD;
      end
      S_MUL_BD: begin
        cmd.mul_bd = 1'b1;
        state_next = S_ABS;
      end
      S_ABS: begin
        cmd.absval = 1'b1;
        state_next = S_GCD;
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          state_next = S_DN_GO;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DN_GO: begin
        cmd.div_start = 1'b1;
        state_next = S_DN;
      end
      S_DN: begin
        if (stat.div_done) begin
          cmd.take_qn = 1'b1;
          state_next = S_DD_GO;
        end
      end
      S_DD_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel = rar_pkg::DIV_SEL_DEN;
        state_next = S_DD;
      end
      S_DD: begin
        if (stat.div_done) begin
          cmd.take_qd = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: design/rar_checker.sv
module rar_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic signed [rar_pkg::PROD_W-1:0] sum_num,
  input logic        [rar_pkg::SDEN_W-1:0] sum_den,
  input logic                              bad_den
);

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result shown while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("result strobe longer than one cycle");

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && bad_den |-> sum_num == '0 && sum_den == rar_pkg::SDEN_W'(1))
    else $error("bad denominator result is not 0/1");

  a_den_pos: assert property (@(posedge clk) disable iff (rst)
    done |-> sum_den != '0) else $error("zero denominator in result");

endmodule

bind rational_add_reduce_core rar_checker u_rar_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .sum_num (sum_num),
  .sum_den (sum_den),
  .bad_den (bad_den)
);
